// ===== sv/mtmvm_pkg.sv =====
// shared types, sizes and opcode constants of the memory-to-memory machine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mtmvm_pkg;
   localparam int MemWords  = 16384;
   localparam int AddrW     = $clog2(MemWords);
   localparam int WordW     = 32;
   localparam int InsnWords = 4;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_STEP  = 2'd2;

   localparam logic [WordW-1:0] OP_ADD  = 32'd1;
   localparam logic [WordW-1:0] OP_SUB  = 32'd2;
   localparam logic [WordW-1:0] OP_MUL  = 32'd3;
   localparam logic [WordW-1:0] OP_DIV  = 32'd4;
   localparam logic [WordW-1:0] OP_MOD  = 32'd5;
   localparam logic [WordW-1:0] OP_AND  = 32'd6;
   localparam logic [WordW-1:0] OP_OR   = 32'd7;
   localparam logic [WordW-1:0] OP_XOR  = 32'd8;
   localparam logic [WordW-1:0] OP_NOT  = 32'd9;
   localparam logic [WordW-1:0] OP_LNOT = 32'd10;
   localparam logic [WordW-1:0] OP_SHL  = 32'd11;
   localparam logic [WordW-1:0] OP_SHR  = 32'd12;
   localparam logic [WordW-1:0] OP_SAR  = 32'd13;
   localparam logic [WordW-1:0] OP_GT   = 32'd14;
   localparam logic [WordW-1:0] OP_EQ   = 32'd15;

   // alu completion status towards the sequencer
   typedef struct packed {
      logic             done;
      logic             wr;
      logic             fault;
      logic [WordW-1:0] value;
   } alu_res_type;
endpackage
`default_nettype wire

// ===== sv/mtmvm_ram.sv =====
// generic single-write single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module mtmvm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== sv/mtmvm_alu.sv =====
// shared arithmetic unit: combinational ops with a registered result and a bit-serial signed divider
// depends on mtmvm_pkg
`timescale 1ns / 1ps
`default_nettype none
module mtmvm_alu (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [mtmvm_pkg::WordW-1:0]  op,
   input  wire logic [mtmvm_pkg::WordW-1:0]  x,
   input  wire logic [mtmvm_pkg::WordW-1:0]  y,
   output mtmvm_pkg::alu_res_type            res
);
   localparam logic [1:0] A_IDLE = 2'd0;
   localparam logic [1:0] A_DIV  = 2'd1;
   localparam logic [1:0] A_FIN  = 2'd2;

   logic [1:0]                  st_ff, st_in;
   logic [4:0]                  cnt_ff, cnt_in;
   logic [mtmvm_pkg::WordW-1:0] rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic                        qneg_ff, qneg_in, rneg_ff, rneg_in, ismod_ff, ismod_in;
   mtmvm_pkg::alu_res_type      res_ff, res_in;
   logic [mtmvm_pkg::WordW+1:0] trial;
   logic [mtmvm_pkg::WordW-1:0] simple;
   logic [4:0]                  sh;
   logic                        simple_wr;

   assign sh    = y[4:0];
   assign trial = {1'b0, rem_ff, quo_ff[mtmvm_pkg::WordW-1]} - {2'b00, dsr_ff};

   always_comb begin
      simple    = '0;
      simple_wr = 1'b1;
      case (op)
         mtmvm_pkg::OP_ADD:  simple = x + y;
         mtmvm_pkg::OP_SUB:  simple = x - y;
         mtmvm_pkg::OP_MUL:  simple = x * y;
         mtmvm_pkg::OP_AND:  simple = x & y;
         mtmvm_pkg::OP_OR:   simple = x | y;
         mtmvm_pkg::OP_XOR:  simple = x ^ y;
         mtmvm_pkg::OP_NOT:  simple = ~x;
         mtmvm_pkg::OP_LNOT: simple = {31'd0, x == '0};
         mtmvm_pkg::OP_SHL:  simple = x << sh;
         mtmvm_pkg::OP_SHR:  simple = x >> sh;
         mtmvm_pkg::OP_SAR:  simple = $unsigned($signed(x) >>> sh);
         mtmvm_pkg::OP_GT:   simple = {31'd0, $signed(x) > $signed(y)};
         mtmvm_pkg::OP_EQ:   simple = {31'd0, x == y};
         default:            simple_wr = 1'b0;
      endcase
   end

   always_comb begin
      st_in    = st_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      qneg_in  = qneg_ff;
      rneg_in  = rneg_ff;
      ismod_in = ismod_ff;
      res_in   = '0;
      case (st_ff)
         A_IDLE: begin
            if (start) begin
               if (op == mtmvm_pkg::OP_DIV || op == mtmvm_pkg::OP_MOD) begin
                  if (y == '0) begin
                     // zero divisor: div gives all ones, mod the dividend
                     res_in.done  = 1'b1;
                     res_in.wr    = 1'b1;
                     res_in.fault = 1'b1;
                     res_in.value = (op == mtmvm_pkg::OP_DIV) ? '1 : x;
                  end else begin
                     st_in    = A_DIV;
                     cnt_in   = '0;
                     rem_in   = '0;
                     quo_in   = x[mtmvm_pkg::WordW-1] ? -x : x;
                     dsr_in   = y[mtmvm_pkg::WordW-1] ? -y : y;
                     qneg_in  = x[mtmvm_pkg::WordW-1] ^ y[mtmvm_pkg::WordW-1];
                     rneg_in  = x[mtmvm_pkg::WordW-1];
                     ismod_in = (op == mtmvm_pkg::OP_MOD);
                  end
               end else begin
                  res_in.done  = 1'b1;
                  res_in.wr    = simple_wr;
                  res_in.value = simple;
               end
            end
         end
         A_DIV: begin
            if (!trial[mtmvm_pkg::WordW+1]) begin
               rem_in = trial[mtmvm_pkg::WordW-1:0];
               quo_in = {quo_ff[mtmvm_pkg::WordW-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[mtmvm_pkg::WordW-2:0], quo_ff[mtmvm_pkg::WordW-1]};
               quo_in = {quo_ff[mtmvm_pkg::WordW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               st_in = A_FIN;
            end
         end
         A_FIN: begin
            // sign fix-up; min by minus one wraps back to min naturally
            res_in.done = 1'b1;
            res_in.wr   = 1'b1;
            if (ismod_ff) begin
               res_in.value = rneg_ff ? -rem_ff : rem_ff;
            end else begin
               res_in.value = qneg_ff ? -quo_ff : quo_ff;
            end
            st_in = A_IDLE;
         end
         default: st_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= A_IDLE;
         res_ff <= '0;
      end else begin
         st_ff  <= st_in;
         res_ff <= res_in;
      end
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dsr_ff   <= dsr_in;
      qneg_ff  <= qneg_in;
      rneg_ff  <= rneg_in;
      ismod_ff <= ismod_in;
   end

   assign res = res_ff;

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (st_ff == A_FIN) |=> res_ff.done)
      else $error("divider finished without completion");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (st_ff == A_DIV) |-> !res_ff.done)
      else $error("completion while dividing");
   a_fault_wr: assert property (@(posedge clock) disable iff (reset)
      res_ff.fault |-> (res_ff.done && res_ff.wr))
      else $error("fault without a write");
endmodule
`default_nettype wire

// ===== sv/memory_to_memory_vm_core.sv =====
// memory-to-memory machine: sequencer, word store and shared alu
// depends on mtmvm_pkg, mtmvm_ram, mtmvm_alu
// a step with div or mod by a non-zero divisor also waits for the bit-serial divider
// throughput: one transaction at a time, as req_tready is high only while the sequencer is idle
// reset: synchronous; afterwards a clearing pass zeroes all 16384 words of the store
// and req_tready stays low until it ends
`timescale 1ns / 1ps
`default_nettype none
module memory_to_memory_vm_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // address[13:0], write_data[45:14], zero pad
   input  wire logic [1:0]  req_tuser,  // mode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // read_data[31:0], instruction_pointer[45:32], zero pad
   output logic [1:0]       rsp_tuser   // halted[0], divide_fault[1]
);
   localparam int AW = mtmvm_pkg::AddrW;
   localparam int WW = mtmvm_pkg::WordW;

   // sequencer states
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RDW   = 4'd2;
   localparam logic [3:0] S_FETCH = 4'd3;
   localparam logic [3:0] S_CAPT  = 4'd4;
   localparam logic [3:0] S_EXEC  = 4'd5;
   localparam logic [3:0] S_WAIT  = 4'd6;
   localparam logic [3:0] S_INCR  = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;

   logic [3:0]    st_ff, st_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [2:0]    idx_ff, idx_in;
   logic [WW-1:0] ip_ff, ip_in;           // shadow of word 0
   logic [1:0]    mode_ff, mode_in;
   logic          halt_ff, halt_in;
   logic          fault_ff, fault_in;
   logic [WW-1:0] rd_ff, rd_in;
   logic [WW-1:0] op_ff, op_in, a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [WW-1:0] x_ff, x_in, y_ff, y_in;
   logic          ov_ff, ov_in;           // output register holds a transaction
   logic [WW-1:0] ord_ff, ord_in;
   logic [AW-1:0] oip_ff, oip_in;
   logic          ohalt_ff, ohalt_in, ofault_ff, ofault_in;

   logic          accept;
   logic [1:0]    req_mode;
   logic [AW-1:0] req_addr;
   logic [WW-1:0] req_data;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [WW-1:0] ram_wdata, ram_rdata;
   logic          alu_start;
   mtmvm_pkg::alu_res_type alu_res;

   assign req_mode   = req_tuser;
   assign req_addr   = req_tdata[AW-1:0];
   assign req_data   = req_tdata[45:14];
   assign req_tready = (st_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign alu_start  = (st_ff == S_EXEC);

   mtmvm_ram #(.WIDTH(WW), .DEPTH(mtmvm_pkg::MemWords)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   mtmvm_alu u_alu (
      .clock (clock),
      .reset (reset),
      .start (alu_start),
      .op    (op_ff),
      .x     (x_ff),
      .y     (y_ff),
      .res   (alu_res)
   );

   // read address: item address when idle, else instruction words then operands
   always_comb begin
      case (idx_ff)
         3'd4:    ram_raddr = a_ff[AW-1:0];
         3'd5:    ram_raddr = b_ff[AW-1:0];
         default: ram_raddr = ip_ff[AW-1:0] + AW'(idx_ff);
      endcase
      if (st_ff == S_IDLE) begin
         ram_raddr = req_addr;
      end
   end

   always_comb begin
      st_in     = st_ff;
      clr_in    = clr_ff;
      idx_in    = idx_ff;
      ip_in     = ip_ff;
      mode_in   = mode_ff;
      halt_in   = halt_ff;
      fault_in  = fault_ff;
      rd_in     = rd_ff;
      op_in     = op_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      ov_in     = ov_ff && !rsp_tready;
      ord_in    = ord_ff;
      oip_in    = oip_ff;
      ohalt_in  = ohalt_ff;
      ofault_in = ofault_ff;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      case (st_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(mtmvm_pkg::MemWords - 1)) begin
               st_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               mode_in  = req_mode;
               halt_in  = (req_mode == mtmvm_pkg::MODE_STEP) && (ip_ff == '0);
               fault_in = 1'b0;
               rd_in    = '0;
               idx_in   = '0;
               case (req_mode)
                  mtmvm_pkg::MODE_WRITE: begin
                     ram_we    = 1'b1;
                     ram_waddr = req_addr;
                     ram_wdata = req_data;
                     if (req_addr == '0) begin
                        ip_in = req_data;
                     end
                     st_in = S_RESP;
                  end
                  mtmvm_pkg::MODE_READ: st_in = S_RDW;
                  mtmvm_pkg::MODE_STEP: st_in = (ip_ff == '0) ? S_RESP : S_FETCH;
                  default:              st_in = S_RESP;
               endcase
            end
         end
         S_RDW: begin
            rd_in = ram_rdata;
            st_in = S_RESP;
         end
         S_FETCH: st_in = S_CAPT;
         S_CAPT: begin
            // read data of the address issued in the cycle before
            case (idx_ff)
               3'd0:    op_in = ram_rdata;
               3'd1:    a_in  = ram_rdata;
               3'd2:    b_in  = ram_rdata;
               3'd3:    c_in  = ram_rdata;
               3'd4:    x_in  = ram_rdata;
               default: y_in  = ram_rdata;
            endcase
            idx_in = idx_ff + 3'd1;
            st_in  = (idx_ff == 3'd5) ? S_EXEC : S_FETCH;
         end
         S_EXEC: st_in = S_WAIT;
         S_WAIT: begin
            if (alu_res.done) begin
               fault_in = alu_res.fault;
               if (alu_res.wr) begin
                  ram_we    = 1'b1;
                  ram_waddr = c_ff[AW-1:0];
                  ram_wdata = alu_res.value;
                  rd_in     = alu_res.value;
                  if (c_ff[AW-1:0] == '0) begin
                     ip_in = alu_res.value;
                  end
               end
               st_in = S_INCR;
            end
         end
         S_INCR: begin
            // word 0 as left by the result write, advanced by one instruction
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = ip_ff + WW'(mtmvm_pkg::InsnWords);
            ip_in     = ip_ff + WW'(mtmvm_pkg::InsnWords);
            st_in     = S_RESP;
         end
         S_RESP: begin
            if (!ov_ff || rsp_tready) begin
               ov_in     = 1'b1;
               ord_in    = rd_ff;
               oip_in    = ip_ff[AW-1:0];
               ofault_in = fault_ff;
               ohalt_in  = (mode_ff == mtmvm_pkg::MODE_WRITE ||
                            mode_ff == mtmvm_pkg::MODE_READ) ? (ip_ff == '0) : halt_ff;
               st_in     = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_CLEAR;
         clr_ff <= '0;
         ov_ff  <= 1'b0;
         ip_ff  <= '0;
      end else begin
         st_ff  <= st_in;
         clr_ff <= clr_in;
         ov_ff  <= ov_in;
         ip_ff  <= ip_in;
      end
      idx_ff    <= idx_in;
      mode_ff   <= mode_in;
      halt_ff   <= halt_in;
      fault_ff  <= fault_in;
      rd_ff     <= rd_in;
      op_ff     <= op_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      ord_ff    <= ord_in;
      oip_ff    <= oip_in;
      ohalt_ff  <= ohalt_in;
      ofault_ff <= ofault_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {2'b00, 14'(oip_ff), ord_ff};
   assign rsp_tuser  = {ofault_ff, ohalt_ff};

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_CLEAR) |-> !req_tready)
      else $error("transaction taken during clearing pass");
   a_fault_divmod: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_RESP && fault_ff) |->
         (op_ff == mtmvm_pkg::OP_DIV || op_ff == mtmvm_pkg::OP_MOD))
      else $error("divide fault on a non-divide opcode");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !rsp_tready) |=> (ov_ff && $stable(ord_ff)))
      else $error("pending result lost");
   a_alu_done_wait: assert property (@(posedge clock) disable iff (reset)
      alu_res.done |-> (st_ff == S_WAIT))
      else $error("alu completion outside wait state");
endmodule
`default_nettype wire
